// File: sv/uvsaq_pkg.sv
`default_nettype none

package uvsaq_pkg;

	localparam int unsigned PowerWaitMsDef = 80;

	localparam int unsigned AccW = 58;
	localparam int unsigned RndBits = 21;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_TIMER = 2'd1;
	localparam logic [1:0] MODE_BUS   = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	localparam logic [7:0] REG_CONF  = 8'h00;
	localparam logic [7:0] REG_UVA   = 8'h07;
	localparam logic [7:0] REG_UVB   = 8'h09;
	localparam logic [7:0] REG_COMP1 = 8'h0A;
	localparam logic [7:0] REG_COMP2 = 8'h0B;

	localparam logic [2:0] IntCodeMax = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE        = 3'd0,
		CMD_POWER_ON    = 3'd1,
		CMD_WRITE_CONF  = 3'd2,
		CMD_START_TIMER = 3'd3,
		CMD_READ_REG    = 3'd4,
		CMD_DONE_OFF    = 3'd5,
		CMD_ERROR_OFF   = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_RUN_ENABLE = 3'd0,
		CFG_INT_CODE   = 3'd1,
		CFG_COEF_UVA_V = 3'd2,
		CFG_COEF_UVA_I = 3'd3,
		CFG_COEF_UVB_V = 3'd4,
		CFG_COEF_UVB_I = 3'd5,
		CFG_RESP_UVA   = 3'd6,
		CFG_RESP_UVB   = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_OFF   = 3'd0,
		PH_POWER = 3'd1,
		PH_CONF  = 3'd2,
		PH_CONV  = 3'd3,
		PH_UVA   = 3'd4,
		PH_UVB   = 3'd5,
		PH_COMP1 = 3'd6,
		PH_COMP2 = 3'd7
	} phase_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_CALC = 1'b1
	} ctl_state_t;

	typedef enum logic [3:0] {
		CS_A0  = 4'd0,
		CS_A1  = 4'd1,
		CS_A2  = 4'd2,
		CS_B0  = 4'd3,
		CS_B1  = 4'd4,
		CS_X0  = 4'd5,
		CS_X1  = 4'd6,
		CS_X2  = 4'd7,
		CS_FIN = 4'd8
	} calc_step_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        launch_ok;
		logic        xfer_ok;
		logic [15:0] read_word;
	} evt_word_t;

	typedef struct packed {
		cmd_t               command;
		logic [9:0]         timer_ms;
		logic [7:0]         bus_register;
		logic [15:0]        write_word;
		logic               result_valid;
		logic signed [31:0] uva_comp;
		logic signed [31:0] uvb_comp;
		logic signed [31:0] uv_index;
	} res_word_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [23:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic       out_load;
		cmd_t       out_cmd;
		logic [7:0] out_reg;
		logic       cap_uva;
		logic       cap_uvb;
		logic       cap_comp1;
		logic       cap_comp2;
		logic       calc_en;
		calc_step_t calc_step;
		logic       fin_load;
	} dp_cmd_t;

	typedef struct packed {
		logic run_enable;
		logic out_free;
	} dp_sts_t;

	function automatic logic [2:0] eff_code(input logic [2:0] code);
		return (code > IntCodeMax) ? IntCodeMax : code;
	endfunction

	// conversion wait, 1.1x integration time
	function automatic logic [9:0] conv_wait_ms(input logic [2:0] eff);
		logic [9:0] ms;
		case (eff)
			3'd0: ms = 10'd55;
			3'd1: ms = 10'd110;
			3'd2: ms = 10'd220;
			3'd3: ms = 10'd440;
			default: ms = 10'd880;
		endcase
		return ms;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [31:0] r;
		if (v[AccW-1:31] != {(AccW-31){v[AccW-1]}}) begin
			r = v[AccW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/uvsaq_evt_if.sv
`default_nettype none

interface uvsaq_evt_if import uvsaq_pkg::*; ();
	logic      valid;
	logic      ready;
	evt_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/uvsaq_res_if.sv
`default_nettype none

interface uvsaq_res_if import uvsaq_pkg::*; ();
	logic      valid;
	logic      ready;
	res_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/uvsaq_cfg_if.sv
`default_nettype none

interface uvsaq_cfg_if import uvsaq_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/uvsaq_ctrl.sv
`default_nettype none

module uvsaq_ctrl import uvsaq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  logic [1:0] mode,
	input  logic       launch_ok,
	input  logic       xfer_ok,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	ctl_state_t st_q, st_d;
	phase_t     ph_q, ph_d;
	logic       pend_q, pend_d;
	calc_step_t step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ph_q   <= PH_OFF;
			pend_q <= 1'b0;
			step_q <= CS_A0;
		end else begin
			st_q   <= st_d;
			ph_q   <= ph_d;
			pend_q <= pend_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		st_d          = st_q;
		ph_d          = ph_q;
		pend_d        = pend_q;
		step_d        = step_q;
		evt_ready     = 1'b0;
		cmd           = '0;
		cmd.out_cmd   = CMD_NONE;
		cmd.calc_step = step_q;
		unique case (st_q)
			ST_IDLE: begin
				evt_ready = sts.out_free;
				if (evt_valid && sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.run_enable && mode != MODE_RSVD) begin
						if (ph_q == PH_OFF) begin
							if (mode == MODE_TICK || pend_q) begin
								pend_d      = 1'b0;
								ph_d        = PH_POWER;
								cmd.out_cmd = CMD_POWER_ON;
							end
						end else if (mode == MODE_TICK) begin
							pend_d = 1'b1;
						end else begin
							unique case (ph_q)
								PH_OFF: begin
								end
								PH_POWER: begin
									if (mode == MODE_TIMER) begin
										if (!launch_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											ph_d        = PH_CONF;
											cmd.out_cmd = CMD_WRITE_CONF;
											cmd.out_reg = REG_CONF;
										end
									end
								end
								PH_CONF: begin
									if (mode == MODE_BUS) begin
										if (!xfer_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											ph_d        = PH_CONV;
											cmd.out_cmd = CMD_START_TIMER;
										end
									end
								end
								PH_CONV: begin
									if (mode == MODE_TIMER) begin
										if (!launch_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											ph_d        = PH_UVA;
											cmd.out_cmd = CMD_READ_REG;
											cmd.out_reg = REG_UVA;
										end
									end
								end
								PH_UVA: begin
									if (mode == MODE_BUS) begin
										if (!xfer_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											cmd.cap_uva = 1'b1;
											if (!launch_ok) begin
												ph_d        = PH_OFF;
												cmd.out_cmd = CMD_ERROR_OFF;
											end else begin
												ph_d        = PH_UVB;
												cmd.out_cmd = CMD_READ_REG;
												cmd.out_reg = REG_UVB;
											end
										end
									end
								end
								PH_UVB: begin
									if (mode == MODE_BUS) begin
										if (!xfer_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											cmd.cap_uvb = 1'b1;
											if (!launch_ok) begin
												ph_d        = PH_OFF;
												cmd.out_cmd = CMD_ERROR_OFF;
											end else begin
												ph_d        = PH_COMP1;
												cmd.out_cmd = CMD_READ_REG;
												cmd.out_reg = REG_COMP1;
											end
										end
									end
								end
								PH_COMP1: begin
									if (mode == MODE_BUS) begin
										if (!xfer_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											cmd.cap_comp1 = 1'b1;
											if (!launch_ok) begin
												ph_d        = PH_OFF;
												cmd.out_cmd = CMD_ERROR_OFF;
											end else begin
												ph_d        = PH_COMP2;
												cmd.out_cmd = CMD_READ_REG;
												cmd.out_reg = REG_COMP2;
											end
										end
									end
								end
								PH_COMP2: begin
									if (mode == MODE_BUS) begin
										if (!xfer_ok) begin
											ph_d        = PH_OFF;
											cmd.out_cmd = CMD_ERROR_OFF;
										end else begin
											// result comes from the compensation pass
											cmd.out_load  = 1'b0;
											cmd.cap_comp2 = 1'b1;
											ph_d          = PH_OFF;
											st_d          = ST_CALC;
											step_d        = CS_A0;
										end
									end
								end
							endcase
						end
					end
				end
			end
			ST_CALC: begin
				cmd.calc_en = 1'b1;
				if (step_q == CS_FIN) begin
					if (sts.out_free) begin
						cmd.fin_load = 1'b1;
						st_d         = ST_IDLE;
					end
				end else begin
					step_d = calc_step_t'(step_q + 4'd1);
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/uvsaq_dp.sv
`default_nettype none

module uvsaq_dp import uvsaq_pkg::*; #(
	parameter int unsigned POWER_WAIT_MS = PowerWaitMsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	uvsaq_cfg_if.sink   cfg,
	uvsaq_res_if.source res,
	input  logic [15:0] read_word,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts
);

	logic               run_en_q;
	logic [2:0]         int_code_q;
	logic signed [15:0] cva_q, cia_q, cvb_q, cib_q;
	logic [23:0]        resp_a_q, resp_b_q;

	logic signed [15:0] raw_uva_q, raw_uvb_q, raw_c1_q, raw_c2_q;
	logic signed [31:0] last_index_q;
	logic signed [31:0] ua_q, ub_q;
	logic signed [AccW-1:0] prod_q, acc_q;

	logic               res_valid_q;
	res_word_t          res_q;

	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic [2:0]         eff;
	logic signed [AccW-1:0] rnd, quo;
	logic signed [31:0] idx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en_q   <= 1'b0;
			int_code_q <= 3'd1;
			cva_q      <= 16'sd9093;
			cia_q      <= 16'sd5448;
			cvb_q      <= 16'sd12083;
			cib_q      <= 16'sd7127;
			resp_a_q   <= 24'd24512;
			resp_b_q   <= 24'd43470;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				CFG_RUN_ENABLE: run_en_q   <= cfg.data.value[0];
				CFG_INT_CODE:   int_code_q <= cfg.data.value[2:0];
				CFG_COEF_UVA_V: cva_q      <= cfg.data.value[15:0];
				CFG_COEF_UVA_I: cia_q      <= cfg.data.value[15:0];
				CFG_COEF_UVB_V: cvb_q      <= cfg.data.value[15:0];
				CFG_COEF_UVB_I: cib_q      <= cfg.data.value[15:0];
				CFG_RESP_UVA:   resp_a_q   <= cfg.data.value;
				CFG_RESP_UVB:   resp_b_q   <= cfg.data.value;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_uva_q <= '0;
			raw_uvb_q <= '0;
			raw_c1_q  <= '0;
		end else begin
			if (cmd.cap_uva) raw_uva_q <= read_word;
			if (cmd.cap_uvb) raw_uvb_q <= read_word;
			if (cmd.cap_comp1) raw_c1_q <= read_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_comp2) raw_c2_q <= read_word;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = {{17{cva_q[15]}}, cva_q};
		mul_b = {{9{raw_c1_q[15]}}, raw_c1_q};
		case (cmd.calc_step)
			CS_A1: begin
				mul_a = {{17{cia_q[15]}}, cia_q};
				mul_b = {{9{raw_c2_q[15]}}, raw_c2_q};
			end
			CS_A2: begin
				mul_a = {{17{cvb_q[15]}}, cvb_q};
				mul_b = {{9{raw_c1_q[15]}}, raw_c1_q};
			end
			CS_B0: begin
				mul_a = {{17{cib_q[15]}}, cib_q};
				mul_b = {{9{raw_c2_q[15]}}, raw_c2_q};
			end
			CS_B1: begin
				mul_a = {ua_q[31], ua_q};
				mul_b = {1'b0, resp_a_q};
			end
			CS_X1: begin
				mul_a = {ub_q[31], ub_q};
				mul_b = {1'b0, resp_b_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_en) begin
			prod_q <= mul_a * mul_b;
			case (cmd.calc_step)
				CS_A0: acc_q <= {{(AccW-28){raw_uva_q[15]}}, raw_uva_q, 12'b0};
				CS_A1, CS_A2, CS_B1: acc_q <= acc_q - prod_q;
				CS_B0: begin
					ua_q  <= sat32(acc_q);
					acc_q <= {{(AccW-28){raw_uvb_q[15]}}, raw_uvb_q, 12'b0} - prod_q;
				end
				CS_X0: begin
					ub_q  <= sat32(acc_q);
					acc_q <= prod_q;
				end
				CS_X2: acc_q <= acc_q + prod_q;
				default: begin
				end
			endcase
		end
	end

	// divide by 2^21, truncating toward zero
	assign rnd = acc_q + {{(AccW-RndBits){1'b0}}, {RndBits{acc_q[AccW-1]}}};
	assign quo = rnd >>> RndBits;
	assign idx = sat32(quo);
	assign eff = eff_code(int_code_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
		end else if (cmd.fin_load) begin
			last_index_q <= idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load || cmd.fin_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			res_q.command      <= CMD_DONE_OFF;
			res_q.timer_ms     <= '0;
			res_q.bus_register <= '0;
			res_q.write_word   <= '0;
			res_q.result_valid <= 1'b1;
			res_q.uva_comp     <= ua_q;
			res_q.uvb_comp     <= ub_q;
			res_q.uv_index     <= idx;
		end else if (cmd.out_load) begin
			res_q.command      <= cmd.out_cmd;
			res_q.timer_ms     <= (cmd.out_cmd == CMD_POWER_ON) ? 10'(POWER_WAIT_MS) :
				(cmd.out_cmd == CMD_START_TIMER) ? conv_wait_ms(eff) : 10'd0;
			res_q.bus_register <= cmd.out_reg;
			res_q.write_word   <= (cmd.out_cmd == CMD_WRITE_CONF) ?
				{9'b0, eff, 4'b0010} : 16'h0000;
			res_q.result_valid <= 1'b0;
			res_q.uva_comp     <= '0;
			res_q.uvb_comp     <= '0;
			res_q.uv_index     <= last_index_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.data       = res_q;
	assign sts.run_enable = run_en_q;
	assign sts.out_free   = !res_valid_q || res.ready;

endmodule

`default_nettype wire

// File: sv/uv_sensor_acquire_sequencer_unit.sv
// UV sensor measurement sequencer.
// evt: one event word per handshake (period tick, timer done, bus complete),
//   with launch/transfer status and the word read by a finished transfer.
// res: exactly one result word per event word: the next command for the
//   sensor bus/timer, and on the last read the compensated UVA/UVB and index.
// cfg: register writes (index, value), always ready; write only while idle.
// A result word is registered at the clock edge that takes its event word,
//   so an event is taken every cycle while results drain, outside the compensation pass.
// The last read (COMP2) runs a compensation pass on one shared
//   33x25 multiplier and accumulator, stepping A0 to X2 and then FIN,
//   and evt.ready stays low until its result word is loaded.
// A stalled res holds its word; evt.ready drops until the output
//   register frees up.
// Reset: sensor sequence off, no pending tick, last index zero,
//   registers at their documented defaults, no result pending.
`default_nettype none

module uv_sensor_acquire_sequencer_unit import uvsaq_pkg::*; #(
	parameter int unsigned POWER_WAIT_MS = PowerWaitMsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	uvsaq_cfg_if.sink   cfg,
	uvsaq_evt_if.sink   evt,
	uvsaq_res_if.source res
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;
	logic    evt_ready;

	assign evt.ready = evt_ready;

	uvsaq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt_ready),
		.mode      (evt.data.mode),
		.launch_ok (evt.data.launch_ok),
		.xfer_ok   (evt.data.xfer_ok),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	uvsaq_dp #(
		.POWER_WAIT_MS (POWER_WAIT_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.res       (res),
		.read_word (evt.data.read_word),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

endmodule

`default_nettype wire

// File: dv/uvsaq_tb_pkg.sv
`timescale 1ns / 1ps

package uvsaq_tb_pkg;
	import uvsaq_pkg::*;

	class acq_scoreboard;
		bit                 run_en;
		logic [2:0]         int_code;
		logic signed [15:0] k_uva_vis;
		logic signed [15:0] k_uva_ir;
		logic signed [15:0] k_uvb_vis;
		logic signed [15:0] k_uvb_ir;
		logic [23:0]        resp_uva;
		logic [23:0]        resp_uvb;
		phase_t             ph;
		logic signed [15:0] uva_raw;
		logic signed [15:0] uvb_raw;
		logic signed [15:0] comp1_raw;
		bit                 pend;
		logic signed [31:0] last_idx;
		res_word_t          words_due[$];
		int                 errors;

		function new();
			run_en    = 1'b0;
			int_code  = 3'd1;
			k_uva_vis = 16'sd9093;
			k_uva_ir  = 16'sd5448;
			k_uvb_vis = 16'sd12083;
			k_uvb_ir  = 16'sd7127;
			resp_uva  = 24'd24512;
			resp_uvb  = 24'd43470;
			ph        = PH_OFF;
			uva_raw   = '0;
			uvb_raw   = '0;
			comp1_raw = '0;
			pend      = 1'b0;
			last_idx  = '0;
			errors    = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [23:0] v);
			case (idx)
				CFG_RUN_ENABLE: run_en = v[0];
				CFG_INT_CODE:   int_code = v[2:0];
				CFG_COEF_UVA_V: k_uva_vis = v[15:0];
				CFG_COEF_UVA_I: k_uva_ir = v[15:0];
				CFG_COEF_UVB_V: k_uvb_vis = v[15:0];
				CFG_COEF_UVB_I: k_uvb_ir = v[15:0];
				CFG_RESP_UVA:   resp_uva = v;
				CFG_RESP_UVB:   resp_uvb = v;
				default: ;
			endcase
		endfunction

		function logic signed [31:0] clip32(longint v);
			if (v > longint'(32'sh7FFF_FFFF))
				return 32'sh7FFF_FFFF;
			if (v < longint'(32'sh8000_0000))
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function logic signed [31:0] compensate(logic signed [15:0] raw, logic signed [15:0] kv,
				logic signed [15:0] ki, logic signed [15:0] c2);
			return clip32(longint'(raw) * 4096 - longint'(kv) * longint'(comp1_raw)
				- longint'(ki) * longint'(c2));
		endfunction

		function res_word_t next_word(evt_word_t e);
			res_word_t          r;
			logic [2:0]         ec;
			logic signed [15:0] w;
			logic signed [31:0] ua;
			logic signed [31:0] ub;
			longint             sum;
			longint             mag;
			longint             q;
			r = '0;
			r.command = CMD_NONE;
			r.uv_index = last_idx;
			ec = (int_code > IntCodeMax) ? IntCodeMax : int_code;
			w = e.read_word;
			if (!run_en || e.mode == MODE_RSVD)
				return r;
			if (ph == PH_OFF) begin
				if (e.mode == MODE_TICK || pend) begin
					pend = 1'b0;
					ph = PH_POWER;
					r.command = CMD_POWER_ON;
					r.timer_ms = 10'(PowerWaitMsDef);
				end
				return r;
			end
			if (e.mode == MODE_TICK) begin
				pend = 1'b1;
				return r;
			end
			case (ph)
				PH_POWER, PH_CONV: begin
					if (e.mode == MODE_TIMER) begin
						if (!e.launch_ok) begin
							ph = PH_OFF;
							r.command = CMD_ERROR_OFF;
						end else if (ph == PH_POWER) begin
							ph = PH_CONF;
							r.command = CMD_WRITE_CONF;
							r.bus_register = REG_CONF;
							r.write_word = {9'd0, ec, 4'b0010};
						end else begin
							ph = PH_UVA;
							r.command = CMD_READ_REG;
							r.bus_register = REG_UVA;
						end
					end
				end
				PH_CONF: begin
					if (e.mode == MODE_BUS) begin
						if (!e.xfer_ok) begin
							ph = PH_OFF;
							r.command = CMD_ERROR_OFF;
						end else begin
							ph = PH_CONV;
							r.command = CMD_START_TIMER;
							case (ec)
								3'd0: r.timer_ms = 10'd55;
								3'd1: r.timer_ms = 10'd110;
								3'd2: r.timer_ms = 10'd220;
								3'd3: r.timer_ms = 10'd440;
								default: r.timer_ms = 10'd880;
							endcase
						end
					end
				end
				PH_UVA, PH_UVB, PH_COMP1: begin
					if (e.mode == MODE_BUS) begin
						if (!e.xfer_ok) begin
							ph = PH_OFF;
							r.command = CMD_ERROR_OFF;
						end else begin
							case (ph)
								PH_UVA: uva_raw = w;
								PH_UVB: uvb_raw = w;
								default: comp1_raw = w;
							endcase
							if (!e.launch_ok) begin
								ph = PH_OFF;
								r.command = CMD_ERROR_OFF;
							end else begin
								r.command = CMD_READ_REG;
								case (ph)
									PH_UVA: r.bus_register = REG_UVB;
									PH_UVB: r.bus_register = REG_COMP1;
									default: r.bus_register = REG_COMP2;
								endcase
								ph = phase_t'(ph + 3'd1);
							end
						end
					end
				end
				default: begin
					if (e.mode == MODE_BUS) begin
						ph = PH_OFF;
						if (!e.xfer_ok) begin
							r.command = CMD_ERROR_OFF;
						end else begin
							ua = compensate(uva_raw, k_uva_vis, k_uva_ir, w);
							ub = compensate(uvb_raw, k_uvb_vis, k_uvb_ir, w);
							sum = longint'(ua) * longint'(resp_uva) + longint'(ub) * longint'(resp_uvb);
							mag = (sum < 0) ? -sum : sum;
							q = mag >> 21;
							if (sum < 0)
								q = -q;
							last_idx = clip32(q);
							r.command = CMD_DONE_OFF;
							r.result_valid = 1'b1;
							r.uva_comp = ua;
							r.uvb_comp = ub;
							r.uv_index = last_idx;
						end
					end
				end
			endcase
			return r;
		endfunction

		function void take_event(evt_word_t e);
			words_due.push_back(next_word(e));
		endfunction

		function void check_word(res_word_t got);
			res_word_t want;
			bit        bad;
			if (words_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: cmd=%0d", got.command);
				return;
			end
			want = words_due.pop_front();
			bad = (got.command !== want.command) || (got.timer_ms !== want.timer_ms)
				|| (got.bus_register !== want.bus_register)
				|| (got.write_word !== want.write_word)
				|| (got.result_valid !== want.result_valid)
				|| (got.uva_comp !== want.uva_comp) || (got.uvb_comp !== want.uvb_comp)
				|| (got.uv_index !== want.uv_index);
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp cmd=%0d ms=%0d reg=%h ww=%h rv=%b ua=%0d ub=%0d ix=%0d",
						want.command, want.timer_ms, want.bus_register, want.write_word,
						want.result_valid, want.uva_comp, want.uvb_comp, want.uv_index,
						" | got cmd=%0d ms=%0d reg=%h ww=%h rv=%b ua=%0d ub=%0d ix=%0d",
						got.command, got.timer_ms, got.bus_register, got.write_word,
						got.result_valid, got.uva_comp, got.uvb_comp, got.uv_index);
			end
		endfunction

		function int outstanding();
			return words_due.size();
		endfunction
	endclass

endpackage

// File: dv/uv_sensor_acquire_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module uv_sensor_acquire_sequencer_unit_tb;
	import uvsaq_pkg::*;
	import uvsaq_tb_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int ItemTarget = 1350;

	logic clk;
	logic arst_n;

	uvsaq_cfg_if cfg();
	uvsaq_evt_if evt();
	uvsaq_res_if res();

	uv_sensor_acquire_sequencer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.evt(evt),
		.res(res)
	);

	acq_scoreboard sb;
	bit            no_idle;
	int            items;
	int            cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [15:0] draw_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_coef(bit extreme);
		logic [23:0] v;
		v = 24'($urandom);
		if (extreme) begin
			case ($urandom_range(0, 3))
				0: v[15:0] = 16'h8000;
				1: v[15:0] = 16'h7FFF;
				2: v[15:0] = 16'h0000;
				default: v[15:0] = 16'hFFFF;
			endcase
		end else if ($urandom_range(0, 1)) begin
			v[15:0] = 16'($urandom_range(0, 16384));
		end
		return v;
	endfunction

	function automatic logic [23:0] pick_resp(bit extreme);
		logic [23:0] v;
		v = 24'($urandom);
		if (extreme)
			v = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
		else if ($urandom_range(0, 1))
			v = 24'($urandom_range(0, 65535));
		return v;
	endfunction

	task automatic push_event(logic [1:0] m, bit lk, bit xk, logic [15:0] w);
		int        gap;
		evt_word_t e;
		gap = draw_gap();
		e = '{mode: m, launch_ok: lk, xfer_ok: xk, read_word: w};
		repeat (gap) begin
			@(negedge clk);
			evt.valid <= 1'b0;
		end
		@(negedge clk);
		evt.valid <= 1'b1;
		evt.data <= e;
		do @(posedge clk); while (!evt.ready);
		sb.take_event(e);
		items++;
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [23:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: idx, value: v};
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		evt.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_config(bit extreme, bit run);
		logic [23:0] v;
		v = 24'($urandom);
		v[0] = run;
		cfg_write(CFG_RUN_ENABLE, v);
		cfg_write(CFG_INT_CODE, 24'($urandom));
		cfg_write(CFG_COEF_UVA_V, pick_coef(extreme));
		cfg_write(CFG_COEF_UVA_I, pick_coef(extreme));
		cfg_write(CFG_COEF_UVB_V, pick_coef(extreme));
		cfg_write(CFG_COEF_UVB_I, pick_coef(extreme));
		cfg_write(CFG_RESP_UVA, pick_resp(extreme));
		cfg_write(CFG_RESP_UVB, pick_resp(extreme));
	endtask

	// one measurement; fault_at picks the step that fails (0: none)
	task automatic run_measurement(int fault_at, int noise_pct);
		logic [1:0] want;
		bit         stop;
		bit         lk;
		bit         xk;
		int         s;
		stop = 1'b0;
		if (!sb.pend && $urandom_range(0, 99) < noise_pct)
			push_event($urandom_range(0, 1) ? MODE_TIMER : MODE_BUS,
				1'($urandom), 1'($urandom), 16'($urandom));
		if (sb.pend && $urandom_range(0, 1))
			push_event($urandom_range(0, 1) ? MODE_TIMER : MODE_BUS,
				1'($urandom), 1'($urandom), 16'($urandom));
		else
			push_event(MODE_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
		for (s = 1; s <= 7 && !stop; s++) begin
			want = (s == 1 || s == 3) ? MODE_TIMER : MODE_BUS;
			if ($urandom_range(0, 99) < noise_pct) begin
				case ($urandom_range(0, 2))
					0: push_event(MODE_RSVD, 1'($urandom), 1'($urandom), 16'($urandom));
					1: push_event(MODE_TICK, 1'($urandom), 1'($urandom), 16'($urandom));
					default: push_event((want == MODE_TIMER) ? MODE_BUS : MODE_TIMER,
						1'($urandom), 1'($urandom), 16'($urandom));
				endcase
			end
			lk = 1'($urandom);
			xk = 1'($urandom);
			case (s)
				1, 3: lk = (fault_at != s);
				2, 7: xk = (fault_at != s);
				default: begin
					xk = 1'b1;
					lk = 1'b1;
					if (fault_at == s) begin
						if ($urandom_range(0, 1)) begin
							xk = 1'b0;
							lk = 1'($urandom);
						end else begin
							lk = 1'b0;
						end
					end
				end
			endcase
			push_event(want, lk, xk, draw_word());
			stop = (fault_at == s);
		end
	endtask

	// result side
	initial begin
		int gap;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			repeat (gap) begin
				@(negedge clk);
				res.ready <= 1'b0;
			end
			@(negedge clk);
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			sb.check_word(res.data);
		end
	end

	initial begin
		int p;
		int fault;
		sb = new();
		no_idle = 1'b0;
		items = 0;
		arst_n = 1'b0;
		evt.valid = 1'b0;
		evt.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// disabled: ignored
		push_event(MODE_TICK, 1'b1, 1'b1, 16'h1234);
		push_event(MODE_TIMER, 1'b1, 1'b1, 16'h0000);
		drain();
		cfg_write(CFG_RUN_ENABLE, 24'd1);
		push_event(MODE_RSVD, 1'b1, 1'b1, 16'hFFFF);
		// full pass at reset coefficients, tick held while busy
		push_event(MODE_TICK, 1'b0, 1'b0, 16'h0000);
		push_event(MODE_TICK, 1'b1, 1'b1, 16'hFFFF);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h5555);
		push_event(MODE_TIMER, 1'b1, 1'b0, 16'hAAAA);
		push_event(MODE_TIMER, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_BUS, 1'b0, 1'b1, 16'hFFFF);
		push_event(MODE_TIMER, 1'b1, 1'b0, 16'h0000);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h7FFF);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h8000);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_BUS, 1'b0, 1'b1, 16'hFFFF);
		// idle with pending tick, then failed launch and failed transfer
		push_event(MODE_TIMER, 1'b0, 1'b0, 16'h0001);
		push_event(MODE_TIMER, 1'b0, 1'b1, 16'h0000);
		push_event(MODE_TICK, 1'b0, 1'b0, 16'h0000);
		push_event(MODE_TIMER, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_BUS, 1'b1, 1'b0, 16'h0000);
		// saturation, integration code above range
		drain();
		cfg_write(CFG_INT_CODE, 24'd7);
		cfg_write(CFG_COEF_UVA_V, 24'h00_7FFF);
		cfg_write(CFG_COEF_UVA_I, 24'h00_7FFF);
		cfg_write(CFG_COEF_UVB_V, 24'h00_7FFF);
		cfg_write(CFG_COEF_UVB_I, 24'h00_7FFF);
		cfg_write(CFG_RESP_UVA, 24'hFF_FFFF);
		cfg_write(CFG_RESP_UVB, 24'hFF_FFFF);
		push_event(MODE_TICK, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_TIMER, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_TIMER, 1'b1, 1'b1, 16'h0000);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h7FFF);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h7FFF);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h8000);
		push_event(MODE_BUS, 1'b1, 1'b1, 16'h8000);

		p = 0;
		while (items < ItemTarget) begin
			drain();
			no_idle = (p % 4 == 3);
			set_config(p % 3 == 1, p % 6 != 2);
			repeat ($urandom_range(8, 16)) begin
				fault = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 7) : 0;
				run_measurement(fault, 12);
				if ($urandom_range(0, 19) == 0)
					drain();
			end
			p++;
		end

		drain();
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/uvsaq_pkg.sv
sv/uvsaq_evt_if.sv
sv/uvsaq_res_if.sv
sv/uvsaq_cfg_if.sv
sv/uvsaq_ctrl.sv
sv/uvsaq_dp.sv
sv/uv_sensor_acquire_sequencer_unit.sv
dv/uvsaq_tb_pkg.sv
dv/uv_sensor_acquire_sequencer_unit_tb.sv
